// ----- rtl/core/miq_pkg.sv -----
// ----------------------------------------------------------------------------
// miq_pkg
// shared types and codes for the middle insert queue
// ----------------------------------------------------------------------------
package miq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 11;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

// ----- rtl/core/middle_insert_queue_top.sv -----
// ----------------------------------------------------------------------------
// middle_insert_queue_top
// ordered queue with append, insert at middle and pop head, held as two
// ring halves in block memories
// ----------------------------------------------------------------------------
// flow: the accepted word and both ring head reads are registered, the exec
//   state writes back and registers the result word; no new word is taken in
//   exec or while a result is held (read at accept, modify and write next cycle)
// reset: pointers, sizes, state and output valid cleared at once; ring
//   memory contents are not cleared and need no clearing pass
module middle_insert_queue_top
  import miq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // popped_value, occupancy, zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int unsigned Half = (CAPACITY + 1) / 2;
  localparam int unsigned AW   = (Half > 1) ? $clog2(Half) : 1;
  localparam int unsigned SW   = $clog2(Half + 1);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    if (p == AW'(Half - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
    if (p == '0) begin
      return AW'(Half - 1);
    end
    return p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                             input logic [SW-1:0] n);
    logic [SW:0] s;
    s = (SW+1)'(p) + (SW+1)'(n);
    if (s >= (SW+1)'(Half)) begin
      s = s - (SW+1)'(Half);
    end
    return AW'(s);
  endfunction

  state_e state_q, state_d;

  logic [AW-1:0] front_head_q, front_head_d;
  logic [SW-1:0] front_size_q, front_size_d;
  logic [AW-1:0] back_head_q, back_head_d;
  logic [SW-1:0] back_size_q, back_size_d;

  op_e             op_q;
  logic [DataW-1:0] value_q;

  logic [DataW-1:0] front_mem [Half];
  logic [DataW-1:0] back_mem [Half];
  logic [DataW-1:0] front_rd_q;
  logic [DataW-1:0] back_rd_q;

  logic             front_we, back_we;
  logic [AW-1:0]    front_wa, back_wa;
  logic [DataW-1:0] front_wd, back_wd;

  logic             out_valid_q;
  logic [DataW-1:0] popped_q, popped_d;
  status_e          status_q, status_d;
  logic [OccW-1:0]  occ_q;
  logic [CW-1:0]    count, count_d;
  logic             accept, even, full;
  logic [AW-1:0]    front_tail, back_tail;

  assign accept = s_axis_tvalid && s_axis_tready;

  // fsm next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(s_axis_tuser);
      value_q <= s_axis_tdata;
    end
  end

  // ring memories, read at accept, written in the exec cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_rd_q <= front_mem[front_head_q];
      back_rd_q  <= back_mem[back_head_q];
    end
    if (front_we) begin
      front_mem[front_wa] <= front_wd;
    end
    if (back_we) begin
      back_mem[back_wa] <= back_wd;
    end
  end

  assign count      = CW'(front_size_q) + CW'(back_size_q);
  assign even       = (front_size_q == back_size_q);
  assign full       = (count >= CW'(CAPACITY));
  assign front_tail = ring_add(front_head_q, front_size_q);
  assign back_tail  = ring_add(back_head_q, back_size_q);

  // read, modify, write back
  always_comb begin
    front_head_d = front_head_q;
    front_size_d = front_size_q;
    back_head_d  = back_head_q;
    back_size_d  = back_size_q;
    front_we     = 1'b0;
    front_wa     = front_tail;
    front_wd     = value_q;
    back_we      = 1'b0;
    back_wa      = back_tail;
    back_wd      = value_q;
    popped_d     = '0;
    status_d     = STATUS_OK;
    if (state_q == ST_EXEC) begin
      unique case (op_q)
        OP_APPEND: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else if (!even) begin
            back_we     = 1'b1;
            back_size_d = back_size_q + SW'(1);
          end else if (back_size_q == '0) begin
            front_we     = 1'b1;
            front_size_d = front_size_q + SW'(1);
          end else begin
            // back head crosses the seam, new word lands at back tail
            front_we     = 1'b1;
            front_wd     = back_rd_q;
            front_size_d = front_size_q + SW'(1);
            back_we      = 1'b1;
            back_head_d  = ring_inc(back_head_q);
          end
        end
        OP_INSERT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else if (even) begin
            front_we     = 1'b1;
            front_size_d = front_size_q + SW'(1);
          end else begin
            back_we     = 1'b1;
            back_head_d = ring_dec(back_head_q);
            back_wa     = ring_dec(back_head_q);
            back_size_d = back_size_q + SW'(1);
          end
        end
        OP_POP: begin
          if (count == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            popped_d     = front_rd_q;
            front_head_d = ring_inc(front_head_q);
            if (even) begin
              front_we    = 1'b1;
              front_wd    = back_rd_q;
              back_head_d = ring_inc(back_head_q);
              back_size_d = back_size_q - SW'(1);
            end else begin
              front_size_d = front_size_q - SW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign count_d = CW'(front_size_d) + CW'(back_size_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_head_q <= '0;
      front_size_q <= '0;
      back_head_q  <= '0;
      back_size_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      front_head_q <= front_head_d;
      front_size_q <= front_size_d;
      back_head_q  <= back_head_d;
      back_size_q  <= back_size_d;
      if (state_q == ST_EXEC) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      popped_q <= popped_d;
      status_q <= status_d;
      occ_q    <= OccW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, occ_q, popped_q};
  assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
  a_split_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_size_q == back_size_q) || (front_size_q == back_size_q + SW'(1)))
    else $error("ring halves out of balance");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !s_axis_tready)
    else $error("word accepted while busy");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 m_axis_tvalid)
    else $error("result word missing after accept");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!front_we && !back_we))
    else $error("ring write outside exec cycle");
`endif

endmodule

// ----- sim/middle_insert_queue_checker.sv -----
// ----------------------------------------------------------------------------
// middle_insert_queue_checker
// Watches both stream channels of the middle insert queue. Every word taken
// on the input side is run through a plain ordered-list model of the queue,
// and the result it predicts is queued. Every word given on the output side
// is compared field by field with the oldest prediction. The failure count
// and the number of results still due go to the testbench top.
// ----------------------------------------------------------------------------
module middle_insert_queue_checker
  import miq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [1:0]  s_axis_tuser,   // operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // popped_value, occupancy, zero fill
  input  logic [1:0]  m_axis_tuser,   // status
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DataW-1:0] popped;
    status_e          status;
    logic [OccW-1:0]  occupancy;
  } queue_result_t;

  logic [DataW-1:0] stored_q[$];
  queue_result_t    result_q[$];

  function automatic queue_result_t apply_word(logic [OpW-1:0] op, logic [DataW-1:0] value);
    queue_result_t res;
    res.popped = '0;
    res.status = STATUS_OK;
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (stored_q.size() >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else if (op == OP_APPEND) begin
          stored_q.push_back(value);
        end else begin
          // lands right after the first ceil(n/2) values
          stored_q.insert(int'((stored_q.size() + 1) / 2), value);
        end
      end
      OP_POP: begin
        if (stored_q.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped = stored_q.pop_front();
        end
      end
      default: ;
    endcase
    res.occupancy = OccW'(stored_q.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    fail_count_o++;
    $display("%0t mismatch on %s: got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : watch_words
    queue_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("word with nothing due", m_axis_tdata, '0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[31:0] !== want.popped) begin
            report_mismatch("popped_value", 48'(m_axis_tdata[31:0]), 48'(want.popped));
          end
          if (m_axis_tdata[42:32] !== want.occupancy) begin
            report_mismatch("occupancy", 48'(m_axis_tdata[42:32]), 48'(want.occupancy));
          end
          if (m_axis_tdata[47:43] !== '0) begin
            report_mismatch("zero fill", 48'(m_axis_tdata[47:43]), '0);
          end
          if (m_axis_tuser !== want.status) begin
            report_mismatch("status", 48'(m_axis_tuser), 48'(want.status));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(apply_word(s_axis_tuser, s_axis_tdata));
      end
    end
    pending_o = unsigned'(result_q.size());
  end

endmodule

// ----- sim/middle_insert_queue_top_test.sv -----
// ----------------------------------------------------------------------------
// middle_insert_queue_top_test
// Drives the middle insert queue with a short directed sequence (empty pops,
// an insert into an empty queue, value extremes, the unused operation code),
// then random traffic that fills the queue past full, drains a good part of
// it and mixes operations, with random stalls on both sides. A checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module middle_insert_queue_top_test;
  import miq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned    Capacity = 1024;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic        steady;
  int unsigned stored_count;
  int unsigned fail_count;
  int unsigned pending;

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 31);
  end

  middle_insert_queue_top #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  middle_insert_queue_checker #(
    .CAPACITY(Capacity)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_word(input logic [OpW-1:0] op, input logic [DataW-1:0] value);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      OP_APPEND, OP_INSERT: if (stored_count < Capacity) stored_count++;
      OP_POP:               if (stored_count > 0) stored_count--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [OpW-1:0] pick_op(input int unsigned push_pct);
    if ($urandom_range(0, 99) < 4) return OpUnused;
    if ($urandom_range(0, 99) < push_pct) return $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
    return OP_POP;
  endfunction

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_APPEND;
    steady        = 1'b0;
    stored_count  = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue, unused code, value extremes, even and odd middle inserts
    send_word(OP_POP, 32'hFFFF_FFFF);
    send_word(OpUnused, 32'h1234_5678);
    send_word(OP_INSERT, 32'h7FFF_FFFF);
    send_word(OP_POP, $urandom);
    send_word(OP_APPEND, 32'h8000_0000);
    send_word(OP_APPEND, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_INSERT, 32'h0000_0001);
    send_word(OP_APPEND, 32'h5555_5555);
    send_word(OP_INSERT, 32'hAAAA_AAAA);
    send_word(OpUnused, 32'hFFFF_FFFF);
    repeat (7) send_word(OP_POP, $urandom);
    send_word(OpUnused, 32'h0000_0000);
    wait_drained();

    repeat (100) send_word(pick_op(55), $urandom);

    // fill to full, the first stretch without stalls
    n = 0;
    while (stored_count < Capacity) begin
      steady = (n < 300);
      send_word(pick_op(95), $urandom);
      n++;
    end
    steady = 1'b0;
    repeat (20) send_word(pick_op(70), $urandom);

    repeat (300) send_word(pick_op(5), $urandom);

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS middle_insert_queue_top");
    end else begin
      $display("FAIL middle_insert_queue_top");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL middle_insert_queue_top");
    $finish;
  end

endmodule
